[rtl/tiny_8bit_cpu_core_top_macros.svh]
// Assertion macros used by the core's top-level RTL file.
`ifndef TINY_8BIT_CPU_CORE_TOP_MACROS_SVH
`define TINY_8BIT_CPU_CORE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define T8CPU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define T8CPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/t8cpu_pkg.sv]
// Shared types, opcodes and status codes of the 8-bit core.
package t8cpu_pkg;

  localparam int MEM_DEPTH     = 256;
  localparam int ADDR_W        = 8;
  localparam int DATA_W        = 8;
  localparam int DEF_REG_COUNT = 8;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  localparam logic [7:0] OP_NOP   = 8'h00;
  localparam logic [7:0] OP_MOV   = 8'h01;
  localparam logic [7:0] OP_ADD   = 8'h02;
  localparam logic [7:0] OP_SUB   = 8'h03;
  localparam logic [7:0] OP_JMP   = 8'h04;
  localparam logic [7:0] OP_PRINT = 8'h05;
  localparam logic [7:0] OP_HALT  = 8'hFF;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_PRINT   = 3'd1;
  localparam logic [2:0] ST_HALT    = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_STOPPED = 3'd4;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] load_address;
    logic [DATA_W-1:0] load_data;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] opcode_address;
    logic [DATA_W-1:0] opcode_seen;
    logic [2:0]        print_register;
    logic [DATA_W-1:0] print_value;
  } rsp_t;

endpackage

[rtl/tiny_8bit_cpu_core_top.sv]
// Top level of the 8-bit core: instruction sequencer, program memory and register file.
//
//   channel  | signals                         | direction | beat
//   ---------+---------------------------------+-----------+-------------------------------
//   request  | req_valid, req_ready, req       | in        | load one byte or step once
//   response | rsp_valid, rsp_ready, rsp       | out       | one beat per step, none on load
//
// A load writes its byte when it is accepted. A step passes through the accepting state,
// then one state per byte read from the single-port program memory, and one more for
// PRINT, ADD and SUB, which wait for a register file read. A step while stopped reads
// nothing and passes only through the accepting state and S_STOP.
// Reset is synchronous; valid bits make both memories read as zero right away.
// A result waits in the output register; the sequencer holds its last state while that
// register is still full, and new requests are taken once it is back in idle.
`include "tiny_8bit_cpu_core_top_macros.svh"

module tiny_8bit_cpu_core_top
  import t8cpu_pkg::*;
#(
  parameter int REG_COUNT = DEF_REG_COUNT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int RW = $clog2(REG_COUNT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STOP = 3'd1;
  localparam logic [2:0] S_OP   = 3'd2;
  localparam logic [2:0] S_A    = 3'd3;
  localparam logic [2:0] S_B    = 3'd4;
  localparam logic [2:0] S_EX   = 3'd5;
  localparam logic [2:0] S_PR   = 3'd6;

  logic [2:0]        state, state_next;
  logic [ADDR_W-1:0] pc, pc_next;
  logic              stopped, stopped_next;
  logic [DATA_W-1:0] op, op_next;
  logic [ADDR_W-1:0] op_addr, op_addr_next;
  logic [RW-1:0]     ra, ra_next;
  logic [DATA_W-1:0] va, va_next;

  logic              pm_we, pm_re;
  logic [ADDR_W-1:0] pm_addr;
  logic [DATA_W-1:0] pm_wdata, pm_byte;

  logic              rf_we, rf_re;
  logic [RW-1:0]     rf_addr;
  logic [DATA_W-1:0] rf_wdata, rf_val;

  logic              out_free;
  logic              fin;
  logic [2:0]        fin_status;
  logic [DATA_W-1:0] fin_op;
  logic [2:0]        fin_preg;
  logic [DATA_W-1:0] fin_pval;

  // Register index of every operand byte, folded into the register count.
  logic [RW-1:0] reg_map [MEM_DEPTH];

  for (genvar i = 0; i < MEM_DEPTH; i++) begin : g_map
    assign reg_map[i] = RW'(i % REG_COUNT);
  end

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  // The program memory port is shared: loads write it only while the sequencer is idle.
  assign pm_we    = req_valid && req_ready && (req.mode == MODE_LOAD);
  assign pm_addr  = pm_we ? req.load_address : pc;
  assign pm_wdata = req.load_data;

  t8cpu_ram #(.DEPTH(MEM_DEPTH)) u_prog (
    .clk   (clk),
    .rst   (rst),
    .we    (pm_we),
    .re    (pm_re),
    .addr  (pm_addr),
    .wdata (pm_wdata),
    .rdata (pm_byte)
  );

  t8cpu_ram #(.DEPTH(REG_COUNT)) u_regs (
    .clk   (clk),
    .rst   (rst),
    .we    (rf_we),
    .re    (rf_re),
    .addr  (rf_addr),
    .wdata (rf_wdata),
    .rdata (rf_val)
  );

  always_comb begin
    state_next   = state;
    pc_next      = pc;
    stopped_next = stopped;
    op_next      = op;
    op_addr_next = op_addr;
    ra_next      = ra;
    va_next      = va;
    pm_re        = 1'b0;
    rf_re        = 1'b0;
    rf_we        = 1'b0;
    rf_addr      = ra;
    rf_wdata     = pm_byte;
    fin          = 1'b0;
    fin_status   = ST_DONE;
    fin_op       = op;
    fin_preg     = '0;
    fin_pval     = '0;

    case (state)
      S_IDLE: begin
        if (req_valid && req.mode == MODE_STEP) begin
          op_addr_next = pc;
          op_next      = OP_NOP;
          if (stopped) begin
            state_next = S_STOP;
          end else begin
            pm_re      = 1'b1;
            pc_next    = pc + 8'd1;
            state_next = S_OP;
          end
        end
      end

      S_STOP: begin
        if (out_free) begin
          fin        = 1'b1;
          fin_status = ST_STOPPED;
          state_next = S_IDLE;
        end
      end

      S_OP: begin
        op_next = pm_byte;
        fin_op  = pm_byte;
        if (pm_byte inside {OP_MOV, OP_ADD, OP_SUB, OP_JMP, OP_PRINT}) begin
          pm_re      = 1'b1;
          pc_next    = pc + 8'd1;
          state_next = S_A;
        end else if (out_free) begin
          fin        = 1'b1;
          state_next = S_IDLE;
          if (pm_byte == OP_HALT) begin
            fin_status   = ST_HALT;
            stopped_next = 1'b1;
          end else if (pm_byte != OP_NOP) begin
            fin_status   = ST_UNKNOWN;
            stopped_next = 1'b1;
          end
        end
      end

      S_A: begin
        ra_next = reg_map[pm_byte];
        case (op)
          OP_MOV: begin
            pm_re      = 1'b1;
            pc_next    = pc + 8'd1;
            state_next = S_B;
          end
          OP_ADD, OP_SUB: begin
            pm_re      = 1'b1;
            pc_next    = pc + 8'd1;
            rf_re      = 1'b1;
            rf_addr    = reg_map[pm_byte];
            state_next = S_B;
          end
          OP_JMP: begin
            if (out_free) begin
              fin        = 1'b1;
              pc_next    = pm_byte;
              state_next = S_IDLE;
            end
          end
          OP_PRINT: begin
            rf_re      = 1'b1;
            rf_addr    = reg_map[pm_byte];
            state_next = S_PR;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      S_B: begin
        case (op)
          OP_MOV: begin
            if (out_free) begin
              rf_we      = 1'b1;
              rf_wdata   = pm_byte;
              fin        = 1'b1;
              state_next = S_IDLE;
            end
          end
          OP_ADD, OP_SUB: begin
            // The first operand arrives now; the second is read from the same port.
            va_next    = rf_val;
            rf_re      = 1'b1;
            rf_addr    = reg_map[pm_byte];
            state_next = S_EX;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      S_EX: begin
        if (out_free) begin
          rf_we      = 1'b1;
          rf_wdata   = (op == OP_SUB) ? va - rf_val : va + rf_val;
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_PR: begin
        if (out_free) begin
          fin        = 1'b1;
          fin_status = ST_PRINT;
          fin_preg   = 3'(ra);
          fin_pval   = rf_val;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      stopped   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      pc      <= pc_next;
      stopped <= stopped_next;
      if (fin) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    op_addr <= op_addr_next;
    ra      <= ra_next;
    va      <= va_next;
    if (fin) begin
      rsp.status         <= fin_status;
      rsp.opcode_address <= op_addr;
      rsp.opcode_seen    <= fin_op;
      rsp.print_register <= fin_preg;
      rsp.print_value    <= fin_pval;
    end
  end

  `T8CPU_ASSERT_NEXT(a_load_keeps_pc, req_valid && req_ready && req.mode == MODE_LOAD, $stable(pc) && $stable(stopped), "load changed pc or stop flag")
  `T8CPU_ASSERT_NEXT(a_stop_sticks, stopped, stopped, "stop flag cleared without reset")
  `T8CPU_ASSERT_SAME(a_rf_write_state, rf_we, state == S_B || state == S_EX, "register write outside MOV or ALU state")
  `T8CPU_ASSERT_SAME(a_stopped_fields, rsp_valid && rsp.status == ST_STOPPED, rsp.opcode_seen == 8'd0 && rsp.print_value == 8'd0, "stopped report carries data")

endmodule

[rtl/t8cpu_ram.sv]
// Single-port synchronous RAM with per-entry valid bits; unwritten entries read as zero.
module t8cpu_ram
  import t8cpu_pkg::*;
#(
  parameter int DEPTH = MEM_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [DATA_W-1:0] rd_q;
  logic              rvld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[addr];
    end
  end

  // Valid bits stand in for clearing the array at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[addr] <= 1'b1;
      end
      if (re) begin
        rvld_q <= vld[addr];
      end
    end
  end

  assign rdata = rvld_q ? rd_q : '0;

endmodule

[bench/cpu_step_checker.sv]
// Checker for the 8-bit core: tracks both channels, predicts each step and compares results.
`timescale 1ns / 1ps

module cpu_step_checker
  import t8cpu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   failures,
  output int   outstanding
);

  logic [7:0] core_mem [MEM_DEPTH];
  logic [7:0] core_regs [8];
  logic [7:0] core_pc;
  logic       core_halted;
  rsp_t       due_results [$];
  int         errors = 0;

  function automatic logic [7:0] fetch_byte();
    logic [7:0] b;
    b = core_mem[core_pc];
    core_pc = core_pc + 8'd1;
    return b;
  endfunction

  // Loads only touch memory; every step yields exactly one result.
  task automatic execute_request(input req_t item);
    rsp_t       res;
    logic [7:0] op;
    logic [7:0] ra;
    logic [7:0] rb;
    if (item.mode == MODE_LOAD) begin
      core_mem[item.load_address] = item.load_data;
    end else begin
      res = '0;
      res.opcode_address = core_pc;
      if (core_halted) begin
        res.status = ST_STOPPED;
      end else begin
        op = fetch_byte();
        res.opcode_seen = op;
        res.status = ST_DONE;
        case (op)
          OP_NOP: begin
          end
          OP_MOV: begin
            ra = fetch_byte();
            core_regs[ra[2:0]] = fetch_byte();
          end
          OP_ADD: begin
            ra = fetch_byte();
            rb = fetch_byte();
            core_regs[ra[2:0]] = core_regs[ra[2:0]] + core_regs[rb[2:0]];
          end
          OP_SUB: begin
            ra = fetch_byte();
            rb = fetch_byte();
            core_regs[ra[2:0]] = core_regs[ra[2:0]] - core_regs[rb[2:0]];
          end
          OP_JMP: begin
            core_pc = fetch_byte();
          end
          OP_PRINT: begin
            ra = fetch_byte();
            res.status = ST_PRINT;
            res.print_register = ra[2:0];
            res.print_value = core_regs[ra[2:0]];
          end
          OP_HALT: begin
            core_halted = 1'b1;
            res.status = ST_HALT;
          end
          default: begin
            core_halted = 1'b1;
            res.status = ST_UNKNOWN;
          end
        endcase
      end
      due_results.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < MEM_DEPTH; i++) core_mem[i] = '0;
      for (int i = 0; i < 8; i++) core_regs[i] = '0;
      core_pc = '0;
      core_halted = 1'b0;
      due_results.delete();
    end else begin
      // A result beat always belongs to an earlier step, so check it before predicting.
      if (rsp_valid && rsp_ready) begin
        if (due_results.size() == 0) begin
          if (errors < 10)
            $display("unexpected result beat: status=%0d addr=%02h op=%02h reg=%0d val=%02h",
                     rsp.status, rsp.opcode_address, rsp.opcode_seen,
                     rsp.print_register, rsp.print_value);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (rsp.status !== want.status || rsp.opcode_address !== want.opcode_address ||
              rsp.opcode_seen !== want.opcode_seen ||
              rsp.print_register !== want.print_register ||
              rsp.print_value !== want.print_value) begin
            if (errors < 10)
              $display({"result mismatch: expected status=%0d addr=%02h op=%02h reg=%0d ",
                        "val=%02h, got status=%0d addr=%02h op=%02h reg=%0d val=%02h"},
                       want.status, want.opcode_address, want.opcode_seen,
                       want.print_register, want.print_value,
                       rsp.status, rsp.opcode_address, rsp.opcode_seen,
                       rsp.print_register, rsp.print_value);
            errors++;
          end
        end
      end
      if (req_valid && req_ready) execute_request(req);
    end
    outstanding <= due_results.size();
    failures    <= errors;
  end

endmodule

[bench/testbench.sv]
// Top of the 8-bit core testbench: clock, reset, request and result traffic, and the verdict.
`timescale 1ns / 1ps

module testbench;
  import t8cpu_pkg::*;

  localparam int DIRECTED_ITEMS = 24;
  localparam int RANDOM_ITEMS   = 850;
  localparam int HOLD_CYCLES    = 250;

  localparam logic [7:0] RUN_OPS [6] = '{OP_NOP, OP_MOV, OP_ADD, OP_SUB, OP_JMP, OP_PRINT};

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int         failures;
  int         outstanding;
  int         items_sent = 0;
  int         phase      = 0;
  logic [7:0] loop_addr;

  tiny_8bit_cpu_core_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  cpu_step_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold once the no-idle phase starts.
  initial begin
    bit held;
    int pct;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == 2 && !held) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pct = (phase == 0) ? 82 : (phase == 1) ? 37 : 0;
      rsp_ready <= ($urandom_range(0, 99) >= pct);
    end
  end

  task automatic send_item(input req_t item);
    int pct;
    pct = (phase == 0) ? 37 : (phase == 1) ? 82 : 0;
    while ($urandom_range(0, 99) < pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    items_sent++;
    phase <= (items_sent < 300) ? 0 : (items_sent < 600) ? 1 : 2;
  endtask

  task automatic send_load(input logic [7:0] addr, input logic [7:0] data);
    req_t item;
    item.mode = MODE_LOAD;
    item.load_address = addr;
    item.load_data = data;
    send_item(item);
  endtask

  task automatic send_step();
    req_t item;
    item.mode = MODE_STEP;
    item.load_address = 8'($urandom);
    item.load_data = 8'($urandom);
    send_item(item);
  endtask

  function automatic int op_length(input logic [7:0] op);
    case (op)
      OP_MOV, OP_ADD, OP_SUB: return 3;
      OP_JMP, OP_PRINT:       return 2;
      default:                return 1;
    endcase
  endfunction

  // Between programs the core spins on a self-jump at loop_addr. A new program goes in
  // clear of that jump and ends in its own self-jump; patching the old jump's target
  // then steers the core into it. Jumps inside a program only go forward.
  task automatic load_and_run_program();
    logic [7:0]  op_list [8];
    int unsigned start [9];
    int unsigned n;
    int unsigned len;
    int unsigned tgt;
    int unsigned noise;
    logic [7:0]  base;
    logic [7:0]  a;
    logic [7:0]  term;
    n = $urandom_range(1, 8);
    len = 0;
    for (int i = 0; i < n; i++) begin
      op_list[i] = RUN_OPS[$urandom_range(0, 5)];
      start[i] = len;
      len += op_length(op_list[i]);
    end
    start[n] = len;
    len += 2;
    noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (noise) begin
      if ($urandom_range(0, 2) == 0) begin
        send_step();
      end else begin
        do a = 8'($urandom); while (a == loop_addr || a == loop_addr + 8'd1);
        send_load(a, 8'($urandom));
      end
    end
    base = loop_addr + 8'd2 + 8'($urandom_range(0, 254 - len));
    for (int i = 0; i < n; i++) begin
      a = 8'(base + start[i]);
      send_load(a, op_list[i]);
      case (op_list[i])
        OP_MOV, OP_ADD, OP_SUB: begin
          send_load(a + 8'd1, 8'($urandom));
          send_load(a + 8'd2, 8'($urandom));
        end
        OP_JMP: begin
          tgt = $urandom_range(i + 1, n);
          send_load(a + 8'd1, 8'(base + start[tgt]));
        end
        OP_PRINT: begin
          send_load(a + 8'd1, 8'($urandom));
        end
        default: begin
        end
      endcase
    end
    term = 8'(base + start[n]);
    send_load(term, OP_JMP);
    send_load(term + 8'd1, term);
    send_load(loop_addr + 8'd1, base);
    loop_addr = term;
    repeat (1 + n + $urandom_range(0, 2)) send_step();
  endtask

  initial begin
    logic [7:0] end_op;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty memory runs as a no-op.
    send_step();
    // Move with an out-of-range register index and the largest immediate.
    send_load(8'h01, OP_MOV);
    send_load(8'h02, 8'hFF);
    send_load(8'h03, 8'hFF);
    send_step();
    // Add a register to itself, wrapping past 255.
    send_load(8'h04, OP_ADD);
    send_load(8'h05, 8'h07);
    send_load(8'h06, 8'h0F);
    send_step();
    // Subtract below zero.
    send_load(8'h07, OP_SUB);
    send_load(8'h08, 8'h00);
    send_load(8'h09, 8'h07);
    send_step();
    send_load(8'h0A, OP_PRINT);
    send_load(8'h0B, 8'hF8);
    send_step();
    // Jump to the last address; the print there takes its operand after the counter wraps.
    send_load(8'h0C, OP_JMP);
    send_load(8'h0D, 8'hFF);
    send_step();
    send_load(8'hFF, OP_PRINT);
    send_step();
    // Park the core on a self-jump at address 1.
    send_load(8'h01, OP_JMP);
    send_load(8'h02, 8'h01);
    send_step();
    loop_addr = 8'h01;

    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) load_and_run_program();

    // Halts and unknown opcodes stick until reset, so only the last program ends in one.
    if ($urandom_range(0, 1) == 0) end_op = OP_HALT;
    else end_op = 8'($urandom_range(6, 254));
    send_load(loop_addr, end_op);
    send_step();
    send_step();
    send_step();
    send_load(8'($urandom), 8'($urandom));
    send_step();
    send_step();
    req_valid <= 1'b0;

    @(posedge clk);
    wait (outstanding == 0);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/t8cpu_pkg.sv
rtl/t8cpu_ram.sv
rtl/tiny_8bit_cpu_core_top.sv
bench/cpu_step_checker.sv
bench/testbench.sv
